// File: rtl/core/alle_pkg.sv
// ----------------------------------------------------------------------------
// Array linked list engine package
// Shared widths, codes, state encoding and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package alle_pkg;

   localparam int DEF_CAPACITY = 16;

   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PREPEND = 3'd0,
      ACT_APPEND  = 3'd1,
      ACT_INSERT  = 3'd2,
      ACT_REMOVE  = 3'd3,
      ACT_REPLACE = 3'd4,
      ACT_FIND    = 3'd5,
      ACT_READ    = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK     = 2'd0,
      STS_EMPTY  = 2'd1,
      STS_BADPOS = 2'd2,
      STS_FULL   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_RDNEXT,
      ST_KGET,
      ST_KDATA,
      ST_RELEASE,
      ST_TAKE,
      ST_POP,
      ST_LINK,
      ST_RDVAL,
      ST_VAL,
      ST_FIND,
      ST_RESP
   } state_type;

   // Source of the shared read address of both memories.
   typedef enum logic [1:0] {
      RD_HEAD,
      RD_CUR,
      RD_LINK,
      RD_FREE
   } rd_sel_type;

   // Source of the successor link given to a newly taken slot.
   typedef enum logic [1:0] {
      NXT_NONE,
      NXT_HEAD,
      NXT_ZERO,
      NXT_LINK
   } nxt_sel_type;

   typedef struct packed {
      logic        capture;
      logic        check;
      logic        walk_init;
      logic        step;
      rd_sel_type  rd_sel;
      nxt_sel_type nxt_load;
      logic        k_head;
      logic        k_link;
      logic        pop;
      logic        link_new;
      logic        unlink;
      logic        release_slot;
      logic        take_value;
      logic        write_value;
      logic        set_found;
      logic        respond;
      logic        clear_step;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                chk_ok;
      logic                at_head;
      logic                need_walk;
      logic                step_last;
      logic                find_hit;
      logic                find_last;
      logic                list_empty;
      logic                clear_last;
      logic                out_free;
   } sts_type;

endpackage

// File: rtl/core/alle_ifs.sv
// ----------------------------------------------------------------------------
// Array linked list engine channels
// Valid/ready channel bundles for the command and result streams.
// ----------------------------------------------------------------------------
interface alle_req_if import alle_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic        [ACTION_W-1:0] action;
   logic        [POS_W-1:0]    position;
   logic signed [DATA_W-1:0]   value;

   modport source (output valid, action, position, value, input ready);
   modport sink (input valid, action, position, value, output ready);
   modport monitor (input valid, ready, action, position, value);
endinterface

interface alle_rsp_if import alle_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   value_out;
   logic        [POS_W-1:0]    found_position;
   logic        [STATUS_W-1:0] status;
   logic        [COUNT_W-1:0]  element_count;

   modport source (output valid, value_out, found_position, status, element_count,
                   input ready);
   modport sink (input valid, value_out, found_position, status, element_count,
                 output ready);
   modport monitor (input valid, ready, value_out, found_position, status,
                    element_count);
endinterface

// File: rtl/core/alle_ctrl.sv
// ----------------------------------------------------------------------------
// Array linked list engine controller
// Sequences one command at a time through checks, link walks and updates.
// ----------------------------------------------------------------------------
module alle_ctrl import alle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // Where a command goes once the walk has reached its target slot.
   function automatic state_type after_walk(logic [ACTION_W-1:0] act);
      state_type nxt;
      unique case (act) inside
         ACT_APPEND:             nxt = ST_TAKE;
         ACT_INSERT, ACT_REMOVE: nxt = ST_RDNEXT;
         default:                nxt = ST_RDVAL;
      endcase
      return nxt;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_CUR;
      req_ready  = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check     = 1'b1;
            cmd.walk_init = 1'b1;
            if (!sts.chk_ok) begin
               state_in = ST_RESP;
            end else begin
               unique case (sts.action) inside
                  ACT_PREPEND, ACT_APPEND, ACT_INSERT, ACT_REMOVE, ACT_REPLACE,
                  ACT_READ: begin
                     if (sts.at_head && (sts.action == ACT_REMOVE)) begin
                        cmd.rd_sel = RD_HEAD;
                        cmd.k_head = 1'b1;
                        state_in   = ST_KDATA;
                     end else if (sts.at_head) begin
                        cmd.nxt_load = NXT_HEAD;
                        state_in     = ST_TAKE;
                     end else begin
                        if (sts.action == ACT_APPEND) begin
                           cmd.nxt_load = NXT_ZERO;
                        end
                        if (sts.need_walk) begin
                           cmd.rd_sel = RD_HEAD;
                           state_in   = ST_WALK;
                        end else begin
                           state_in = after_walk(sts.action);
                        end
                     end
                  end
                  ACT_FIND: begin
                     if (sts.list_empty) begin
                        state_in = ST_RESP;
                     end else begin
                        cmd.rd_sel = RD_HEAD;
                        state_in   = ST_FIND;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (sts.step_last) begin
               state_in = after_walk(sts.action);
            end else begin
               cmd.rd_sel = RD_LINK;
            end
         end
         ST_RDNEXT: begin
            cmd.rd_sel = RD_CUR;
            state_in   = (sts.action == ACT_INSERT) ? ST_TAKE : ST_KGET;
         end
         ST_KGET: begin
            cmd.k_link = 1'b1;
            cmd.rd_sel = RD_LINK;
            state_in   = ST_KDATA;
         end
         ST_KDATA: begin
            cmd.take_value = 1'b1;
            cmd.unlink     = 1'b1;
            if (sts.at_head) begin
               cmd.release_slot = 1'b1;
               state_in         = ST_RESP;
            end else begin
               state_in = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            cmd.release_slot = 1'b1;
            state_in         = ST_RESP;
         end
         ST_TAKE: begin
            cmd.rd_sel = RD_FREE;
            if ((sts.action == ACT_INSERT) && !sts.at_head) begin
               cmd.nxt_load = NXT_LINK;
            end
            state_in = ST_POP;
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_LINK;
         end
         ST_LINK: begin
            cmd.link_new = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RDVAL: begin
            cmd.rd_sel = RD_CUR;
            state_in   = ST_VAL;
         end
         ST_VAL: begin
            cmd.take_value  = 1'b1;
            cmd.write_value = (sts.action == ACT_REPLACE);
            state_in        = ST_RESP;
         end
         ST_FIND: begin
            if (sts.find_hit) begin
               cmd.set_found = 1'b1;
               state_in      = ST_RESP;
            end else if (sts.find_last) begin
               state_in = ST_RESP;
            end else begin
               cmd.step   = 1'b1;
               cmd.rd_sel = RD_LINK;
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/alle_dpath.sv
// ----------------------------------------------------------------------------
// Array linked list engine datapath
// Slot memories, list pointers, walk registers and the result register.
// ----------------------------------------------------------------------------
module alle_dpath import alle_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic        [ACTION_W-1:0] req_action,
   input  logic        [POS_W-1:0]    req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic signed [DATA_W-1:0]   rsp_value_out,
   output logic        [POS_W-1:0]    rsp_found_position,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [COUNT_W-1:0]  rsp_element_count
);

   // Slots are numbered 1..CAPACITY; link value zero ends a chain.
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int TW = (LW > POS_W) ? LW : POS_W;

   logic [LW-1:0]     link_mem [CAPACITY];
   logic [DATA_W-1:0] value_mem [CAPACITY];

   logic [LW-1:0]       link_rd_ff;
   logic [DATA_W-1:0]   value_rd_ff;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [LW-1:0]       head_ff, head_in;
   logic [LW-1:0]       fh_ff, fh_in;
   logic [LW-1:0]       count_ff, count_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       idx_ff, idx_in;
   logic [LW-1:0]       nxt_ff, nxt_in;
   logic [LW-1:0]       new_ff, new_in;
   logic [LW-1:0]       k_ff, k_in;
   logic [LW-1:0]       clr_ff, clr_in;
   logic [DATA_W-1:0]   res_vout_ff, res_vout_in;
   logic [LW-1:0]       res_found_ff, res_found_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_vout_ff, out_vout_in;
   logic [POS_W-1:0]    out_found_ff, out_found_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic [LW-1:0]       rd_slot;
   logic                link_we;
   logic [LW-1:0]       link_wslot;
   logic [LW-1:0]       link_wdata;
   logic                value_we;
   logic [LW-1:0]       value_wslot;
   logic [TW-1:0]       tgt;
   logic                full;
   logic                empty;
   logic                pos_ok;
   logic                clear_last;
   logic [STATUS_W-1:0] chk_status;

   function automatic logic [AW-1:0] to_addr(logic [LW-1:0] slot);
      return AW'(slot - LW'(1));
   endfunction

   // Command checks, on the captured command and the count before it.
   always_comb begin
      full   = (count_ff == LW'(CAPACITY));
      empty  = (count_ff == '0);
      pos_ok = (pos_ff != '0) && (TW'(pos_ff) <= TW'(count_ff));

      unique case (action_ff) inside
         ACT_PREPEND, ACT_APPEND: begin
            chk_status = full ? STS_FULL : STS_OK;
         end
         ACT_INSERT: begin
            chk_status = full ? STS_FULL : (pos_ok ? STS_OK : STS_BADPOS);
         end
         ACT_REMOVE, ACT_REPLACE, ACT_READ: begin
            chk_status = empty ? STS_EMPTY : (pos_ok ? STS_OK : STS_BADPOS);
         end
         default: begin
            chk_status = STS_OK;
         end
      endcase

      unique case (action_ff) inside
         ACT_APPEND:             tgt = TW'(count_ff);
         ACT_INSERT, ACT_REMOVE: tgt = TW'(pos_ff) - TW'(1);
         default:                tgt = TW'(pos_ff);
      endcase
   end

   assign clear_last = (clr_ff == LW'(CAPACITY));

   always_comb begin
      sts.action     = action_ff;
      sts.chk_ok     = (chk_status == STS_OK);
      sts.at_head    = (action_ff == ACT_PREPEND)
                    || ((action_ff == ACT_APPEND) && empty)
                    || (((action_ff == ACT_INSERT) || (action_ff == ACT_REMOVE))
                        && (pos_ff == POS_W'(1)));
      sts.need_walk  = (tgt != TW'(1));
      sts.step_last  = ((TW'(idx_ff) + TW'(1)) == tgt);
      sts.find_hit   = (value_rd_ff == val_ff);
      sts.find_last  = (idx_ff == count_ff);
      sts.list_empty = empty;
      sts.clear_last = clear_last;
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD: rd_slot = head_ff;
         RD_CUR:  rd_slot = cur_ff;
         RD_LINK: rd_slot = link_rd_ff;
         RD_FREE: rd_slot = fh_ff;
         default: rd_slot = cur_ff;
      endcase
   end

   // One link write per cycle; the controller never asks for two at once.
   always_comb begin
      link_we    = 1'b0;
      link_wslot = cur_ff;
      link_wdata = '0;
      if (cmd.clear_step) begin
         link_we    = 1'b1;
         link_wslot = clr_ff;
         link_wdata = clear_last ? '0 : clr_ff + LW'(1);
      end else if (cmd.pop) begin
         link_we    = 1'b1;
         link_wslot = fh_ff;
         link_wdata = nxt_ff;
      end else if (cmd.release_slot) begin
         link_we    = 1'b1;
         link_wslot = k_ff;
         link_wdata = fh_ff;
      end else if (cmd.link_new && !sts.at_head) begin
         link_we    = 1'b1;
         link_wdata = new_ff;
      end else if (cmd.unlink && !sts.at_head) begin
         link_we    = 1'b1;
         link_wdata = link_rd_ff;
      end

      value_we    = cmd.pop || cmd.write_value;
      value_wslot = cmd.pop ? fh_ff : cur_ff;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[to_addr(link_wslot)] <= link_wdata;
      end
      link_rd_ff <= link_mem[to_addr(rd_slot)];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[to_addr(value_wslot)] <= val_ff;
      end
      value_rd_ff <= value_mem[to_addr(rd_slot)];
   end

   always_comb begin
      action_in     = action_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      head_in       = head_ff;
      fh_in         = fh_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      nxt_in        = nxt_ff;
      new_in        = new_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      res_vout_in   = res_vout_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      out_vout_in   = out_vout_ff;
      out_found_in  = out_found_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         action_in = req_action;
         pos_in    = req_position;
         val_in    = DATA_W'(req_value);
      end
      if (cmd.check) begin
         res_status_in = chk_status;
         res_vout_in   = '0;
         res_found_in  = '0;
      end
      if (cmd.walk_init) begin
         cur_in = head_ff;
         idx_in = LW'(1);
      end
      if (cmd.step) begin
         cur_in = link_rd_ff;
         idx_in = idx_ff + LW'(1);
      end

      unique case (cmd.nxt_load)
         NXT_HEAD: nxt_in = head_ff;
         NXT_ZERO: nxt_in = '0;
         NXT_LINK: nxt_in = link_rd_ff;
         default:  nxt_in = nxt_ff;
      endcase

      if (cmd.k_head) begin
         k_in = head_ff;
      end
      if (cmd.k_link) begin
         k_in = link_rd_ff;
      end
      if (cmd.pop) begin
         new_in = fh_ff;
         fh_in  = link_rd_ff;
      end
      if (cmd.link_new) begin
         if (sts.at_head) begin
            head_in = new_ff;
         end
         count_in = count_ff + LW'(1);
      end
      if (cmd.unlink && sts.at_head) begin
         head_in = link_rd_ff;
      end
      if (cmd.release_slot) begin
         fh_in    = k_ff;
         count_in = count_ff - LW'(1);
      end
      if (cmd.take_value) begin
         res_vout_in = value_rd_ff;
      end
      if (cmd.set_found) begin
         res_found_in = idx_ff;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + LW'(1);
      end
      if (cmd.respond) begin
         out_valid_in  = 1'b1;
         out_vout_in   = res_vout_ff;
         out_found_in  = POS_W'(res_found_ff);
         out_status_in = res_status_ff;
         out_count_in  = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fh_ff        <= LW'(1);
         count_ff     <= '0;
         clr_ff       <= LW'(1);
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fh_ff        <= fh_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      nxt_ff        <= nxt_in;
      new_ff        <= new_in;
      k_ff          <= k_in;
      res_vout_ff   <= res_vout_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      out_vout_ff   <= out_vout_in;
      out_found_ff  <= out_found_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value_out      = out_vout_ff;
   assign rsp_found_position = out_found_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_element_count  = out_count_ff;

endmodule

// File: rtl/core/array_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Array linked list engine
// Singly linked list of 32-bit values in fixed slots with a free list.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req_ch    in          action, position, value
//   rsp_ch    out         value_out, found_position, status, element_count
//
// One command is worked at a time. Its run length is set by the walk along
// the link chain, one slot per cycle through the single read port of the
// link memory; find on an empty list and rejected commands do no walk.
// After reset the engine chains every slot onto the free list, with
// req_ch.ready low. A result waits in an output register, so a new command
// is taken while rsp_ch is stalled; only the finished command after it
// waits for that register to drain.
// ----------------------------------------------------------------------------
module array_linked_list_engine import alle_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   alle_req_if.sink   req_ch,
   alle_rsp_if.source rsp_ch
);

   // The controller and datapath share only these two bundles.
   cmd_type cmd;
   sts_type sts;

   // The controller owns sequencing: clearing pass, checks, walks, updates.
   alle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the slot memories, the list and free heads, the
   // element count and the result register that drives the rsp_ch beat.
   alle_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_ch.action),
      .req_position       (req_ch.position),
      .req_value          (req_ch.value),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_value_out      (rsp_ch.value_out),
      .rsp_found_position (rsp_ch.found_position),
      .rsp_status         (rsp_ch.status),
      .rsp_element_count  (rsp_ch.element_count)
   );

endmodule

// File: rtl/core/alle_checker.sv
// ----------------------------------------------------------------------------
// Array linked list engine checker
// Port-level properties of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module alle_checker import alle_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [DATA_W-1:0]   rsp_value_out,
   input logic        [POS_W-1:0]    rsp_found_position,
   input logic        [STATUS_W-1:0] rsp_status,
   input logic        [COUNT_W-1:0]  rsp_element_count
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Commands taken whose result beat has not gone out yet.
   always_comb begin
      pending_in = pending_ff + 2'(req_beat) - 2'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
         && $stable(rsp_status) && $stable(rsp_element_count))
      else $error("result beat changed while stalled");

   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result beat without an accepted command");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_position != '0 |->
         rsp_status == STS_OK && rsp_found_position <= rsp_element_count)
      else $error("found position outside the list");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FULL |->
         rsp_element_count == COUNT_W'(CAPACITY))
      else $error("full status with a list that is not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_EMPTY |-> rsp_element_count == '0)
      else $error("empty status with elements on the list");

endmodule

bind array_linked_list_engine alle_checker #(
   .CAPACITY (CAPACITY)
) u_alle_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_value_out      (rsp_ch.value_out),
   .rsp_found_position (rsp_ch.found_position),
   .rsp_status         (rsp_ch.status),
   .rsp_element_count  (rsp_ch.element_count)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array linked list engine testbench
// Drives list commands through the command channel with random gaps and
// stalls. A scoreboard keeps its own copy of the slot list and free list,
// predicts each result and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import alle_pkg::*;

   localparam int          CAP          = DEF_CAPACITY;
   localparam int          RANDOM_ITEMS = 875;
   localparam int          QUIET_ITEMS  = 150;
   // Action code 7 is unused; the engine must answer it without touching the list.
   localparam logic [2:0]  ACT_UNUSED   = 3'd7;

   typedef struct {
      logic signed [DATA_W-1:0] value_out;
      logic [POS_W-1:0]         found_position;
      status_type               status;
      logic [COUNT_W-1:0]       element_count;
   } list_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a private copy of the slot list. Slots are numbered 1..CAP,
   // link 0 ends a chain, exactly as the engine stores them.
   // -------------------------------------------------------------------------
   class list_scoreboard;
      logic signed [DATA_W-1:0] slot_value [0:CAP];
      int                       slot_link [0:CAP];
      int                       head;
      int                       free_head;
      int                       count;
      list_result_type          pending_results [$];
      int                       mismatches;

      function new();
         for (int i = 0; i <= CAP; i++) begin
            slot_value[i] = '0;
            slot_link[i]  = (i > 0 && i < CAP) ? i + 1 : 0;
         end
         head       = 0;
         free_head  = 1;
         count      = 0;
         mismatches = 0;
      endfunction

      // Slot that holds list position p; the caller keeps p in 1..count.
      function int slot_at(int p);
         int s;
         s = head;
         for (int i = 1; i < p; i++) begin
            s = slot_link[s];
         end
         return s;
      endfunction

      // Pops the free head and loads it with a value and an empty link.
      function int take_slot(logic signed [DATA_W-1:0] val);
         int s;
         s                = free_head;
         free_head        = slot_link[s];
         slot_value[s]    = val;
         slot_link[s]     = 0;
         return s;
      endfunction

      // Applies one accepted command beat and queues the result it must give.
      function void note_command(logic [2:0] act, logic [4:0] pos,
                                 logic signed [DATA_W-1:0] val);
         list_result_type r;
         int              s;
         int              prev;
         int              k;
         bit              full;
         bit              pos_ok;
         r.value_out      = '0;
         r.found_position = '0;
         r.status         = STS_OK;
         full             = count >= CAP;
         pos_ok           = pos >= 1 && pos <= count;
         case (act)
            ACT_PREPEND: begin
               if (full) begin
                  r.status = STS_FULL;
               end else begin
                  s            = take_slot(val);
                  slot_link[s] = head;
                  head         = s;
                  count++;
               end
            end
            ACT_APPEND: begin
               if (full) begin
                  r.status = STS_FULL;
               end else begin
                  s = take_slot(val);
                  if (head == 0) begin
                     head = s;
                  end else begin
                     slot_link[slot_at(count)] = s;
                  end
                  count++;
               end
            end
            ACT_INSERT: begin
               // Fullness wins over a bad position.
               if (full) begin
                  r.status = STS_FULL;
               end else if (!pos_ok) begin
                  r.status = STS_BADPOS;
               end else begin
                  s = take_slot(val);
                  if (pos == 1) begin
                     slot_link[s] = head;
                     head         = s;
                  end else begin
                     prev            = slot_at(pos - 1);
                     slot_link[s]    = slot_link[prev];
                     slot_link[prev] = s;
                  end
                  count++;
               end
            end
            ACT_REMOVE: begin
               if (count == 0) begin
                  r.status = STS_EMPTY;
               end else if (!pos_ok) begin
                  r.status = STS_BADPOS;
               end else begin
                  if (pos == 1) begin
                     k    = head;
                     head = slot_link[k];
                  end else begin
                     prev            = slot_at(pos - 1);
                     k               = slot_link[prev];
                     slot_link[prev] = slot_link[k];
                  end
                  r.value_out  = slot_value[k];
                  slot_link[k] = free_head;
                  free_head    = k;
                  count--;
               end
            end
            ACT_REPLACE, ACT_READ: begin
               if (count == 0) begin
                  r.status = STS_EMPTY;
               end else if (!pos_ok) begin
                  r.status = STS_BADPOS;
               end else begin
                  s           = slot_at(pos);
                  r.value_out = slot_value[s];
                  if (act == ACT_REPLACE) begin
                     slot_value[s] = val;
                  end
               end
            end
            ACT_FIND: begin
               s = head;
               for (int i = 1; i <= count; i++) begin
                  if (slot_value[s] == val) begin
                     r.found_position = POS_W'(i);
                     break;
                  end
                  s = slot_link[s];
               end
            end
            default: begin
            end
         endcase
         r.element_count = COUNT_W'(count);
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      // Compares one result beat with the oldest queued expectation.
      task check_result(logic signed [DATA_W-1:0] value_out, logic [4:0] found,
                        logic [1:0] sts, logic [4:0] elems);
         list_result_type e;
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no command outstanding");
            return;
         end
         e = pending_results.pop_front();
         if (value_out !== e.value_out)
            report_mismatch($sformatf("value_out got %0d, expected %0d",
                                      value_out, e.value_out));
         if (found !== e.found_position)
            report_mismatch($sformatf("found_position got %0d, expected %0d",
                                      found, e.found_position));
         if (sts !== e.status)
            report_mismatch($sformatf("status got %0d, expected %0d", sts, e.status));
         if (elems !== e.element_count)
            report_mismatch($sformatf("element_count got %0d, expected %0d",
                                      elems, e.element_count));
      endtask

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the engine.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_on = 1'b0;   // enables gaps on the command side and stalls on results
   bit   grow_mode = 1'b1; // biases random commands toward filling or draining

   list_scoreboard sb = new();

   alle_req_if req_ch ();
   alle_rsp_if rsp_ch ();

   array_linked_list_engine u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both channels are observed at the rising edge, where beats are accepted.
   // The inputs were settled on the previous falling edge, so the order of
   // events inside this time step does not matter.
   always @(posedge clock) begin
      if (req_ch.valid && req_ch.ready)
         sb.note_command(req_ch.action, req_ch.position, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.value_out, rsp_ch.found_position, rsp_ch.status,
                         rsp_ch.element_count);
   end

   // Result side back-pressure: random stall bursts while idling is enabled,
   // otherwise ready stays high.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   // Presents one command beat at the falling edge, optionally after a gap,
   // and returns on the falling edge after the beat was taken. Valid is only
   // written once per falling edge, so back-to-back beats keep it high.
   task automatic send_command(input logic [2:0] act, input logic [4:0] pos,
                               input logic [31:0] val);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.position <= pos;
      req_ch.value    <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Picks a value: often from a small pool so that finds hit and duplicates
   // exist, otherwise any 32-bit pattern.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3, 4, 5: return 32'($urandom_range(0, 5));
         default: return $urandom();
      endcase
   endfunction

   // Positions mostly land inside the list; the rest probe both borders and
   // the whole 5-bit range.
   function automatic logic [4:0] pick_position(int elems);
      int r;
      r = $urandom_range(0, 19);
      if (r < 14)
         return 5'($urandom_range(1, (elems > 0) ? elems : 1));
      else if (r < 16)
         return 5'd0;
      else if (r < 18)
         return 5'(elems + 1);
      else
         return 5'($urandom_range(0, 31));
   endfunction

   // Random command with the action mix steered by the fill direction. The
   // direction flips at the empty and full ends so the list keeps sweeping
   // through every length, and full-list additions occur near the top.
   task automatic send_random_command();
      int         r;
      int         add_w;
      int         rem_w;
      logic [2:0] act;
      if (sb.count >= CAP)
         grow_mode = 1'b0;
      else if (sb.count == 0)
         grow_mode = 1'b1;
      add_w = grow_mode ? 50 : 15;
      rem_w = grow_mode ? 10 : 45;
      r     = $urandom_range(0, 99);
      if (r < add_w) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_PREPEND;
            1:       act = ACT_APPEND;
            default: act = ACT_INSERT;
         endcase
      end else if (r < add_w + rem_w) begin
         act = ACT_REMOVE;
      end else if (r < 97) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_REPLACE;
            1:       act = ACT_FIND;
            default: act = ACT_READ;
         endcase
      end else begin
         act = ACT_UNUSED;
      end
      send_command(act, pick_position(sb.count), pick_value());
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_PREPEND;
      req_ch.position = '0;
      req_ch.value    = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: every command but prepend on an empty list, then a short list
      // built with all three additions and worked from both ends.
      send_command(ACT_REMOVE,  5'd1,  32'd0);
      send_command(ACT_REPLACE, 5'd1,  32'd9);
      send_command(ACT_READ,    5'd1,  32'd0);
      send_command(ACT_FIND,    5'd0,  32'd0);
      send_command(ACT_INSERT,  5'd1,  32'd3);
      send_command(ACT_UNUSED,  5'd0,  32'd0);
      // Appending to an empty list must take the free head.
      send_command(ACT_APPEND,  5'd0,  32'h7fff_ffff);
      send_command(ACT_PREPEND, 5'd0,  32'h8000_0000);
      send_command(ACT_APPEND,  5'd0,  32'hffff_ffff);
      send_command(ACT_INSERT,  5'd1,  32'd0);
      // Insert before the last element, then at both invalid borders.
      send_command(ACT_INSERT,  5'd4,  32'h5555_5555);
      send_command(ACT_INSERT,  5'd0,  32'd1);
      send_command(ACT_INSERT,  5'd6,  32'd1);
      send_command(ACT_READ,    5'd1,  32'd0);
      send_command(ACT_READ,    5'd5,  32'd0);
      send_command(ACT_REPLACE, 5'd3,  32'haaaa_aaaa);
      send_command(ACT_FIND,    5'd0,  32'haaaa_aaaa);
      send_command(ACT_FIND,    5'd0,  32'h1234_5678);
      send_command(ACT_REMOVE,  5'd0,  32'd0);
      send_command(ACT_REMOVE,  5'd31, 32'd0);
      send_command(ACT_REMOVE,  5'd1,  32'd0);
      send_command(ACT_REMOVE,  5'd4,  32'd0);
      send_command(ACT_REMOVE,  5'd2,  32'd0);
      send_command(ACT_READ,    5'd31, 32'd0);
      send_command(ACT_UNUSED,  5'd31, 32'hffff_ffff);

      // Random part. Idling comes and goes in phases so that stretches with
      // and without gaps both occur; the last stretch runs at full rate.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / 120) % 3 != 2);
         send_random_command();
      end
      req_ch.valid <= 1'b0;
      idle_on = 1'b0;

      // Drain the outstanding results, then leave room for a stray beat.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4 * CAP) @(posedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: the slowest correct run needs well under a millisecond.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/alle_pkg.sv
rtl/core/alle_ifs.sv
rtl/core/alle_ctrl.sv
rtl/core/alle_dpath.sv
rtl/core/array_linked_list_engine.sv
rtl/core/alle_checker.sv
sim/tb_top.sv
